// ===== src/rc4_pkg.sv =====
// ============================================================================
// rc4_pkg
// Types and constants shared by the RC4 stream cipher modules.
// ============================================================================
`default_nettype none

package rc4_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int KEY_W       = 64;
  localparam int CFG_ADDR_W  = 8;

  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LOW  = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_HIGH = 8'd1;

  // Key bytes repeat every sixteen schedule steps.
  localparam logic [3:0] KEY_IDX_MASK = 4'hf;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic                we;
    logic [TABLE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re_a;
    logic [TABLE_AW-1:0] raddr_a;
    logic                re_b;
    logic [TABLE_AW-1:0] raddr_b;
  } ram_req_t;

  function automatic logic [7:0] key_byte(logic [KEY_W-1:0] key_lo,
                                          logic [KEY_W-1:0] key_hi,
                                          logic [7:0]       step);
    logic [3:0]       idx;
    logic [KEY_W-1:0] word;
    idx  = step[3:0] & KEY_IDX_MASK;
    word = idx[3] ? key_hi : key_lo;
    return word[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== src/rc4_perm_ram.sv =====
// ============================================================================
// rc4_perm_ram
// Permutation table: one write port, two read ports, registered read data.
// ============================================================================
`default_nettype none

module rc4_perm_ram (
  input  wire logic                          clk,
  input  wire rc4_pkg::ram_req_t             req,
  output logic [7:0]                         rd_a,
  output logic [7:0]                         rd_b
);

  logic [7:0] mem_r [rc4_pkg::TABLE_DEPTH];
  logic [7:0] rd_a_r;
  logic [7:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re_a) begin
      rd_a_r <= mem_r[req.raddr_a];
    end
    if (req.re_b) begin
      rd_b_r <= mem_r[req.raddr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

`default_nettype wire

// ===== src/rc4_ctrl.sv =====
// ============================================================================
// rc4_ctrl
// Sequencer for table fill, key schedule swaps and keystream generation.
// ============================================================================
`default_nettype none

module rc4_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire rc4_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output rc4_pkg::out_item_t                out_data,
  input  wire logic [rc4_pkg::KEY_W-1:0]    key_low,
  input  wire logic [rc4_pkg::KEY_W-1:0]    key_high,
  output rc4_pkg::ram_req_t                 ram_req,
  input  wire logic [7:0]                   rd_a,
  input  wire logic [7:0]                   rd_b
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD_I,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J
  } state_t;

  state_t             state_r;
  logic               pending_r;
  logic               ks_r;
  logic [7:0]         fill_cnt_r;
  logic [7:0]         idx_r;
  logic [7:0]         i_r;
  logic [7:0]         j_r;
  logic [7:0]         si_r;
  logic [7:0]         sj_r;
  logic               hit_i_r;
  logic               hit_j_r;
  rc4_pkg::in_item_t  item_r;
  logic               out_valid_r;
  rc4_pkg::out_item_t out_data_r;

  logic [7:0]         key_add;
  logic [7:0]         j_sum;
  logic [7:0]         t_sum;
  logic               out_free;
  logic               out_load;
  logic [7:0]         ks_byte;
  rc4_pkg::ram_req_t  req;

  assign key_add  = ks_r ? rc4_pkg::key_byte(key_low, key_high, idx_r) : 8'h00;
  assign j_sum    = j_r + rd_a + key_add;
  assign t_sum    = si_r + rd_a;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == ST_WR_J) && !ks_r && out_free;
  // The write of S[i] in the same cycle and the pending write of S[j]
  // are not visible in the read of S[t], so those two cases are bypassed.
  assign ks_byte  = hit_j_r ? si_r : (hit_i_r ? sj_r : rd_b);

  always_comb begin
    req         = '0;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_FILL: begin
        req.we    = 1'b1;
        req.waddr = fill_cnt_r;
        req.wdata = fill_cnt_r;
      end
      ST_RD_I: begin
        req.re_a    = 1'b1;
        req.raddr_a = idx_r;
      end
      ST_RD_J: begin
        req.re_a    = 1'b1;
        req.raddr_a = j_sum;
      end
      ST_WR_I: begin
        req.we      = 1'b1;
        req.waddr   = idx_r;
        req.wdata   = rd_a;
        req.re_b    = 1'b1;
        req.raddr_b = t_sum;
      end
      ST_WR_J: begin
        req.we    = ks_r || out_free;
        req.waddr = j_r;
        req.wdata = si_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pending_r   <= 1'b1;
      ks_r        <= 1'b0;
      i_r         <= 8'h00;
      j_r         <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          fill_cnt_r <= 8'h00;
          if (in_valid) begin
            item_r <= in_data;
            if (pending_r) begin
              pending_r <= 1'b0;
              state_r   <= ST_FILL;
            end else begin
              ks_r    <= 1'b0;
              idx_r   <= i_r + 8'h01;
              state_r <= ST_RD_I;
            end
          end
        end
        ST_FILL: begin
          fill_cnt_r <= fill_cnt_r + 8'h01;
          if (fill_cnt_r == 8'hff) begin
            ks_r    <= 1'b1;
            idx_r   <= 8'h00;
            j_r     <= 8'h00;
            state_r <= ST_RD_I;
          end
        end
        ST_RD_I: begin
          state_r <= ST_RD_J;
        end
        ST_RD_J: begin
          si_r    <= rd_a;
          j_r     <= j_sum;
          state_r <= ST_WR_I;
        end
        ST_WR_I: begin
          sj_r    <= rd_a;
          hit_i_r <= (t_sum == idx_r);
          hit_j_r <= (t_sum == j_r);
          state_r <= ST_WR_J;
        end
        ST_WR_J: begin
          if (ks_r) begin
            if (idx_r == 8'hff) begin
              // Schedule done: the held byte starts with i and j cleared.
              ks_r  <= 1'b0;
              idx_r <= 8'h01;
              j_r   <= 8'h00;
            end else begin
              idx_r <= idx_r + 8'h01;
            end
            state_r <= ST_RD_I;
          end else if (out_free) begin
            out_data_r.cipher_byte <= item_r.data_byte ^ ks_byte;
            out_data_r.last_out    <= item_r.last_byte;
            i_r                    <= idx_r;
            if (item_r.last_byte) begin
              pending_r <= 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign ram_req   = req;

endmodule

`default_nettype wire

// ===== src/rc4_stream_cipher_unit.sv =====
// ============================================================================
// rc4_stream_cipher_unit
// RC4 byte cipher with a 128-bit key held in two configuration registers.
// ============================================================================
//
//   channel | signals                          | moves
//   --------+----------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_data      | one message byte and last flag
//   out     | out_valid, out_ready, out_data   | one cipher byte and last flag
//   cfg     | cfg_we, cfg_addr, cfg_wdata      | key_low (0), key_high (1)
//
// Each byte is accepted and then passes through four dependent
// accesses to the single permutation RAM (read S[i], read S[j], write S[i]
// with read S[t], write S[j]) before the next byte is accepted.
// The first byte of each message is preceded by 256 fill writes and
// 256 key schedule swaps through the same RAM.
// Reset makes the key schedule pending; the table itself is never cleared.
// A stalled result holds the sequencer in its final step; one more byte
// may be accepted while a result waits in the output register.
`default_nettype none

module rc4_stream_cipher_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire rc4_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output rc4_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [rc4_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [rc4_pkg::KEY_W-1:0]         cfg_wdata
);

  logic [rc4_pkg::KEY_W-1:0] key_low_r;
  logic [rc4_pkg::KEY_W-1:0] key_high_r;
  rc4_pkg::ram_req_t         ram_req;
  logic [7:0]                rd_a;
  logic [7:0]                rd_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      // Writes to any other index are dropped.
      unique case (cfg_addr)
        rc4_pkg::CFG_KEY_LOW: begin
          key_low_r <= cfg_wdata;
        end
        rc4_pkg::CFG_KEY_HIGH: begin
          key_high_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .key_low   (key_low_r),
    .key_high  (key_high_r),
    .ram_req   (ram_req),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  rc4_perm_ram u_ram (
    .clk  (clk),
    .req  (ram_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

endmodule

`default_nettype wire

// ===== src/rc4_checker.sv =====
// ============================================================================
// rc4_checker
// Port-level checks on the RC4 cipher unit, bound to the top level.
// ============================================================================
`default_nettype none

module rc4_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire rc4_pkg::out_item_t out_data
);

  // A result that is offered stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the transaction completed");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // A taken byte occupies the sequencer, so in_ready does not stay high.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high right after an input transaction");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after its input transaction");

endmodule

bind rc4_stream_cipher_unit rc4_checker u_rc4_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// RC4 stream cipher unit testbench
// Drives random and hand-picked messages through rc4_stream_cipher_unit under
// several keys and checks every cipher byte against a local RC4 predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int SETTLE_WAIT  = 64;
  localparam int PRINT_CAP    = 40;
  localparam int PHASE_BYTES  = 240;

  typedef enum int {
    PH_DIRECT, PH_FLOW, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH, PH_PRESSURE
  } phase_t;

  // Tracks the RC4 permutation and indices and holds the cipher bytes the
  // block still owes.
  class cipher_scoreboard;
    logic [7:0]         perm [256];
    logic [7:0]         idx_i;
    logic [7:0]         idx_j;
    bit                 rekey_due;
    logic [63:0]        key_lo;
    logic [63:0]        key_hi;
    rc4_pkg::out_item_t owed_cipher [$];
    int                 mismatches;
    int                 checked;

    function new();
      idx_i      = '0;
      idx_j      = '0;
      rekey_due  = 1'b1;
      key_lo     = '0;
      key_hi     = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [rc4_pkg::CFG_ADDR_W-1:0] addr,
                            logic [rc4_pkg::KEY_W-1:0] val);
      if (addr == rc4_pkg::CFG_KEY_LOW) begin
        key_lo = val;
      end else if (addr == rc4_pkg::CFG_KEY_HIGH) begin
        key_hi = val;
      end
    endfunction

    function void schedule_key();
      logic [7:0]  acc;
      logic [7:0]  tmp;
      logic [3:0]  sel;
      logic [63:0] word;
      acc = '0;
      for (int k = 0; k < rc4_pkg::TABLE_DEPTH; k++) perm[k] = k[7:0];
      for (int k = 0; k < rc4_pkg::TABLE_DEPTH; k++) begin
        sel  = k[3:0] & rc4_pkg::KEY_IDX_MASK;
        word = sel[3] ? key_hi : key_lo;
        acc  = acc + perm[k] + word[8*sel[2:0] +: 8];
        tmp       = perm[k];
        perm[k]   = perm[acc];
        perm[acc] = tmp;
      end
      idx_i = '0;
      idx_j = '0;
    endfunction

    // Called for every accepted input transaction.
    function void note_byte(rc4_pkg::in_item_t item);
      rc4_pkg::out_item_t res;
      logic [7:0]         tmp;
      logic [7:0]         t;
      if (rekey_due) begin
        schedule_key();
        rekey_due = 1'b0;
      end
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + perm[idx_i];
      tmp         = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = tmp;
      t = perm[idx_i] + perm[idx_j];
      res.cipher_byte = item.data_byte ^ perm[t];
      res.last_out    = item.last_byte;
      owed_cipher.push_back(res);
      if (item.last_byte) rekey_due = 1'b1;
    endfunction

    task report(string msg);
      if (mismatches < PRINT_CAP) $display("[%0t] MISMATCH %s", $time, msg);
      mismatches++;
    endtask

    task check_cipher(rc4_pkg::out_item_t got);
      rc4_pkg::out_item_t want;
      if (owed_cipher.size() == 0) begin
        report($sformatf("unexpected result byte %02h last %0b",
                         got.cipher_byte, got.last_out));
      end else begin
        want = owed_cipher.pop_front();
        checked++;
        if (got.cipher_byte !== want.cipher_byte)
          report($sformatf("result %0d cipher_byte got %02h want %02h",
                           checked, got.cipher_byte, want.cipher_byte));
        if (got.last_out !== want.last_out)
          report($sformatf("result %0d last_out got %0b want %0b",
                           checked, got.last_out, want.last_out));
      end
    endtask
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  rc4_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  rc4_pkg::out_item_t             out_data;
  logic                           cfg_we    = 1'b0;
  logic [rc4_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [rc4_pkg::KEY_W-1:0]      cfg_wdata = '0;

  cipher_scoreboard cipher_sb = new();

  phase_t phase        = PH_DIRECT;
  int     src_idle_pct = 0;
  int     hold_left    = 0;
  bit     held_once    = 1'b0;
  int     cycles       = 0;
  int     bytes_taken  = 0;
  int     msgs_closed  = 0;
  int     input_stalls = 0;
  int     key_loads    = 0;

  rc4_stream_cipher_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Transactions are sampled right at the edge, before any update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        cipher_sb.note_byte(in_data);
        bytes_taken++;
        if (in_data.last_byte) msgs_closed++;
      end
      if (in_valid && !in_ready) input_stalls++;
      if (out_valid && out_ready) cipher_sb.check_cipher(out_data);
    end
  end

  function automatic int sink_stall_pct(phase_t p);
    case (p)
      PH_SINK_STALL: return 47;
      PH_BOTH, PH_PRESSURE: return 16;
      default: return 0;
    endcase
  endfunction

  // Receiver side; the long hold-off in the pressure phase is counted here.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (phase == PH_PRESSURE && !held_once) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      held_once <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct(phase));
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    rc4_pkg::in_item_t item;
    item.data_byte = data;
    item.last_byte = last;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lowers valid and waits until every owed cipher byte has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (cipher_sb.owed_cipher.size() != 0);
  endtask

  task automatic put_reg(input logic [rc4_pkg::CFG_ADDR_W-1:0] addr,
                         input logic [rc4_pkg::KEY_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cipher_sb.write_reg(addr, val);
  endtask

  // Writes both key halves, optionally followed by a write to an unused index.
  task automatic load_key(input logic [rc4_pkg::KEY_W-1:0] lo,
                          input logic [rc4_pkg::KEY_W-1:0] hi,
                          input bit stray,
                          input logic [rc4_pkg::CFG_ADDR_W-1:0] stray_addr);
    put_reg(rc4_pkg::CFG_KEY_LOW, lo);
    put_reg(rc4_pkg::CFG_KEY_HIGH, hi);
    if (stray) put_reg(stray_addr, {$urandom, $urandom});
    cfg_we <= 1'b0;
    key_loads++;
  endtask

  function automatic logic [rc4_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 1;
    if (r < 90) return $urandom_range(16, 2);
    return $urandom_range(80, 17);
  endfunction

  // The final message of a phase is sometimes left open, so the next key
  // load lands in the middle of a message.
  task automatic run_phase(input phase_t p, input int idle_pct, input int n_bytes);
    int left;
    int len;
    bit close;
    phase        <= p;
    src_idle_pct = idle_pct;
    load_key(pick_key(), pick_key(), 1'($urandom_range(1)),
             rc4_pkg::CFG_KEY_HIGH + 8'd1 + 8'($urandom_range(253)));
    left = n_bytes;
    while (left > 0) begin
      len = pick_len();
      if (len > left) len = left;
      close = (left > len) || ($urandom_range(1) == 1);
      for (int k = 0; k < len; k++)
        send_byte(8'($urandom_range(255)), close && (k == len - 1));
      left -= len;
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset key, then extreme keys and bytes.
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();
    load_key('1, '1, 1'b1, '1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h55, 1'b1);
    drain();
    load_key('0, '1, 1'b1, rc4_pkg::CFG_KEY_HIGH + 8'd1);
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    drain();
    // A new key in mid-message must not touch the rest of that message.
    load_key(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0, '0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hfe, 1'b1);
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b1);
    // Back-to-back single-byte messages rerun the schedule every time.
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h5a, 1'b1);
    drain();

    run_phase(PH_FLOW,       0,  PHASE_BYTES);
    run_phase(PH_SRC_IDLE,   47, PHASE_BYTES);
    run_phase(PH_SINK_STALL, 0,  PHASE_BYTES);
    run_phase(PH_BOTH,       16, PHASE_BYTES);
    run_phase(PH_PRESSURE,   0,  PHASE_BYTES);

    repeat (SETTLE_WAIT) @(posedge clk);
    if (cipher_sb.owed_cipher.size() != 0)
      cipher_sb.report($sformatf("%0d results never arrived", cipher_sb.owed_cipher.size()));

    $display("Run covered %0d bytes in %0d closed messages under %0d key loads.",
             bytes_taken, msgs_closed, key_loads);
    $display("%0d results checked, %0d mismatches, input held back for %0d cycles.",
             cipher_sb.checked, cipher_sb.mismatches, input_stalls);
    if (cipher_sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
